// ===== sv/rtf_pkg.sv =====
// Shared types, constants and helper functions of the RTTY telemetry framer.
// No dependencies; every other file of the block imports this package.
package rtf_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_RESTART     = 16'hFFFF;
    localparam logic [15:0] CRC_AFTER_RESET = 16'hDEAD;
    localparam logic [7:0]  MARK_RESET      = 8'hE0;
    localparam logic [7:0]  TRAILER_STAR    = 8'h2A;
    localparam logic [7:0]  FORCED_BIT      = 8'h80;

    localparam logic [3:0] PERIOD_LAST = 4'd9;
    localparam logic [2:0] TRAILER_CHAR_LAST = 3'd4;

    typedef enum logic [1:0] {
        REQ_SEND    = 2'd0,
        REQ_CKSUM   = 2'd1,
        REQ_RESTART = 2'd2
    } req_type_t;

    // One queued job: a single character, or a trailer with its CRC snapshot.
    typedef struct packed {
        logic        trailer;
        logic [15:0] data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v > 4'd9) begin
            r = 8'({4'd0, v} - 8'd10 + 8'h41);
        end else begin
            r = 8'({4'd0, v} + 8'h30);
        end
        return r;
    endfunction

endpackage

// ===== sv/rtf_front.sv =====
// Request front end: classifies requests, keeps the running CRC-16 and
// pushes character and trailer jobs to the queue. Depends on rtf_pkg.
module rtf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           s_tuser,
    input  rtf_pkg::fifo_status_t q_status,
    output logic                 push,
    output rtf_pkg::job_t        push_job
);
    import rtf_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic        accept;
    logic [15:0] folded;

    // Bytewise CRC-16, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] c_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign folded   = crc_fold(crc_reg, s_tdata);

    always_comb begin
        crc_next = crc_reg;
        push     = 1'b0;
        push_job = '{trailer: 1'b0, data: {8'h00, s_tdata}};
        if (accept) begin
            unique case (s_tuser)
                REQ_SEND: begin
                    crc_next = folded;
                    push     = 1'b1;
                end
                REQ_CKSUM: begin
                    push     = 1'b1;
                    push_job = '{trailer: 1'b1, data: crc_reg};
                end
                REQ_RESTART: begin
                    crc_next = CRC_RESTART;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_AFTER_RESET;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ===== sv/rtf_fifo.sv =====
// Short job queue between the request front end and the bit serializer.
// Depends on rtf_pkg for the job and status types.
module rtf_fifo #(
    parameter int DEPTH = rtf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rtf_pkg::job_t         push_job,
    input  logic                  pop,
    output rtf_pkg::job_t         head_job,
    output rtf_pkg::fifo_status_t status
);
    import rtf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/rtf_back.sv =====
// Bit serializer: turns queued jobs into ten-period RTTY characters and
// drives the registered output channel. Depends on rtf_pkg.
module rtf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            mark_code,
    input  rtf_pkg::job_t         head_job,
    input  rtf_pkg::fifo_status_t q_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import rtf_pkg::*;

    logic        cur_valid_reg, cur_valid_next;
    job_t        cur_job_reg, cur_job_next;
    logic [2:0]  char_idx_reg, char_idx_next;
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_tone_reg, m_tone_next;
    logic        m_last_reg, m_last_next;

    logic        advance, emit, finishing, load;
    logic [7:0]  cur_char, bits;
    logic [2:0]  bit_sel;
    logic        is_mark, is_last;

    always_comb begin
        if (!cur_job_reg.trailer) begin
            cur_char = cur_job_reg.data[7:0];
        end else begin
            unique case (char_idx_reg)
                3'd0:    cur_char = TRAILER_STAR;
                3'd1:    cur_char = hex_digit(cur_job_reg.data[15:12]);
                3'd2:    cur_char = hex_digit(cur_job_reg.data[11:8]);
                3'd3:    cur_char = hex_digit(cur_job_reg.data[7:4]);
                default: cur_char = hex_digit(cur_job_reg.data[3:0]);
            endcase
        end
    end

    assign bits    = cur_char | FORCED_BIT;
    assign bit_sel = 3'(bit_idx_reg - 4'd2);

    // Period 0 is the stop mark, period 1 the start space, then data bits.
    always_comb begin
        unique case (bit_idx_reg)
            4'd0:    is_mark = 1'b1;
            4'd1:    is_mark = 1'b0;
            default: is_mark = bits[bit_sel];
        endcase
    end

    assign is_last = (bit_idx_reg == PERIOD_LAST) &&
                     (!cur_job_reg.trailer || char_idx_reg == TRAILER_CHAR_LAST);

    assign advance   = !m_valid_reg || m_tready;
    assign emit      = advance && cur_valid_reg;
    assign finishing = emit && is_last;
    assign load      = (!cur_valid_reg || finishing) && !q_status.empty;
    assign pop       = load;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_tone_next    = m_tone_reg;
        m_last_next    = m_last_reg;
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        char_idx_next  = char_idx_reg;
        bit_idx_next   = bit_idx_reg;
        if (advance) begin
            m_valid_next = cur_valid_reg;
            m_tone_next  = is_mark ? mark_code : 8'h00;
            m_last_next  = is_last;
        end
        if (load) begin
            cur_valid_next = 1'b1;
            cur_job_next   = head_job;
            char_idx_next  = '0;
            bit_idx_next   = '0;
        end else if (finishing) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            if (bit_idx_reg == PERIOD_LAST) begin
                bit_idx_next  = '0;
                char_idx_next = 3'(char_idx_reg + 1'b1);
            end else begin
                bit_idx_next = 4'(bit_idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_job_reg  <= cur_job_next;
        char_idx_reg <= char_idx_next;
        bit_idx_reg  <= bit_idx_next;
        m_tone_reg   <= m_tone_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tone_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/rtty_telemetry_framer_crc16.sv =====
// Top level of the RTTY telemetry framer with running CRC-16.
// Depends on rtf_pkg, rtf_front, rtf_fifo and rtf_back.
//
//  Channel  Direction  tdata (low bit up)     tuser / tlast
//  -------  ---------  ---------------------  ----------------------------
//  s_       in         [7:0] char_code        tuser [1:0] req_type
//  m_       out        [7:0] tone_code        tlast = last
//  cfg_     in         [7:0] mark_code        write enable cfg_we, no read
//
// A send request produces ten output transactions, one per cycle while the
// output is not stalled, and a checksum request fifty; the bit serializer
// emits one bit period a cycle unless m_tready holds it. The front end
// accepts a request each cycle while the job queue has room, so send requests
// queue up behind a long trailer while restarts take effect without waiting.
// Reset (aresetn low, synchronous) empties the queue and the output register,
// sets the CRC to 0xDEAD and mark_code to 0xE0. A stalled output holds its
// transaction while the queue keeps taking requests until it fills.
module rtty_telemetry_framer_crc16 #(
    parameter int FIFO_DEPTH = rtf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: mark_code register.
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,   // [7:0] mark_code
    // Request channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] char_code
    input  logic [1:0] s_tuser,     // [1:0] req_type
    // Bit period channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] tone_code
    output logic       m_tlast      // last bit period of a request
);
    import rtf_pkg::*;

    logic [7:0]   mark_reg;
    logic         push, pop;
    job_t         push_job, head_job;
    fifo_status_t q_status;

    // The mark code is to be written only while the block is idle; not enforced here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= MARK_RESET;
        end else if (cfg_we) begin
            mark_reg <= cfg_wdata;
        end
    end

    // Front end: CRC bookkeeping and job classification.
    rtf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Job queue decoupling the two halves.
    rtf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back end: serializes characters into bit periods.
    rtf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mark_code (mark_reg),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_status.full))
        else $error("job pushed into a full queue");

    // The serializer never takes a job from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_status.empty))
        else $error("job popped from an empty queue");

    // Every nonzero tone is the configured mark code.
    a_tone_is_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata != 8'h00) |-> (m_tdata == mark_reg))
        else $error("tone code differs from mark code");

endmodule
